// ----- rtl/core/wnm_pkg.sv -----
// ----------------------------------------------------------------------------
// wnm_pkg
// Shared constants and types for the wildcard name matcher: pattern
// capacity, wildcard codes and the control bundle that steers every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package wnm_pkg;

	// Pattern capacity and derived widths
	localparam int MAX_PATTERN = 32;
	localparam int CHAR_W      = 16;
	localparam int POS_W       = $clog2(MAX_PATTERN + 1);
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 8;

	// Wildcard codes
	localparam logic [CHAR_W-1:0] CODE_ANY_ONE = CHAR_W'(16'h003F);
	localparam logic [CHAR_W-1:0] CODE_ANY_RUN = CHAR_W'(16'h002A);

	// Input kinds carried on the slave tuser bit
	localparam logic FUNC_PATTERN = 1'b0;
	localparam logic FUNC_NAME    = 1'b1;

	// Control broadcast from the top level to all cells
	typedef struct packed {
		logic pat_wr;     // pattern character transaction this cycle
		logic new_pat;    // that character opens a fresh pattern
		logic name_step;  // name character transaction this cycle
		logic use_start;  // position set equals the start set
		logic code_star;  // incoming code is the any-run wildcard
		logic code_any;   // incoming code is the any-one wildcard
	} wnm_ctl_t;

	// One result transaction
	typedef struct packed {
		logic pattern_overflow;
		logic matched;
	} wnm_result_t;

endpackage : wnm_pkg

`default_nettype wire

// ----- rtl/core/wnm_cell.sv -----
// ----------------------------------------------------------------------------
// wnm_cell
// One pattern position: holds its pattern character, its start-set bit and
// its active bit, and passes the step token and star closure to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module wnm_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire wnm_pkg::wnm_ctl_t         ctl,
	input  wire logic [wnm_pkg::CHAR_W-1:0] code,
	input  wire logic                      first,     // this is position zero
	input  wire logic                      wr_sel,    // pattern write targets this cell
	input  wire logic                      valid,     // position lies inside the pattern
	input  wire logic                      link_in,   // start bit handed from the left
	input  wire logic                      carry_in,  // step token from the left
	input  wire logic                      close_in,  // star closure from the left
	output logic                           link_out,
	output logic                           carry_out,
	output logic                           close_out,
	output logic                           closed     // updated position bit
);

	import wnm_pkg::*;

	logic [CHAR_W-1:0] char_q;
	logic              star_q;
	logic              any_q;
	logic              start_q;
	logic              active_q;

	logic base_start;
	logic cur;
	logic star_v;
	logic next_bit;

	// Start bit as it stands before this write
	assign base_start = ctl.new_pat ? first : start_q;
	assign link_out   = wr_sel & base_start & ctl.code_star;

	// Step this position on a name character
	assign cur       = ctl.use_start ? start_q : active_q;
	assign star_v    = valid & star_q;
	assign carry_out = cur & valid & ~star_q & (any_q | (char_q == code));
	assign next_bit  = carry_in | (cur & star_v);
	assign closed    = next_bit | close_in;
	assign close_out = closed & star_v;

	// Hold the pattern character
	always_ff @(posedge clk) begin
		if (ctl.pat_wr && wr_sel) begin
			char_q <= code;
			star_q <= ctl.code_star;
			any_q  <= ctl.code_any;
		end
	end

	// Advance the start and active bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= first;
			active_q <= first;
		end else begin
			if (ctl.pat_wr) begin
				start_q <= base_start | link_in;
			end
			if (ctl.name_step) begin
				active_q <= closed;
			end
		end
	end

endmodule : wnm_cell

`default_nettype wire

// ----- rtl/core/wnm_out_buf.sv -----
// ----------------------------------------------------------------------------
// wnm_out_buf
// Two-entry output buffer: a head register and a skid register, so a new
// transaction is taken while a finished result still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module wnm_out_buf (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire wnm_pkg::wnm_result_t  push_data,
	output logic                       space,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output wnm_pkg::wnm_result_t       out_data
);

	import wnm_pkg::*;

	logic        head_vld_q;
	logic        skid_vld_q;
	wnm_result_t head_q;
	wnm_result_t skid_q;
	logic        pop;

	assign space     = ~skid_vld_q;
	assign out_valid = head_vld_q;
	assign out_data  = head_q;
	assign pop       = head_vld_q & out_ready;

	// Hold result payloads
	always_ff @(posedge clk) begin
		if (pop && skid_vld_q) begin
			head_q <= skid_q;
		end else if (push && (pop || !head_vld_q)) begin
			head_q <= push_data;
		end
		if (push && head_vld_q && !pop) begin
			skid_q <= push_data;
		end
	end

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				head_vld_q <= skid_vld_q | push;
				skid_vld_q <= 1'b0;
			end else if (push) begin
				head_vld_q <= 1'b1;
				skid_vld_q <= head_vld_q;
			end
		end
	end

endmodule : wnm_out_buf

`default_nettype wire

// ----- rtl/core/wildcard_name_matcher_top.sv -----
// ----------------------------------------------------------------------------
// wildcard_name_matcher_top
// Wildcard file name matcher: a row of pattern cells tracks the set of
// reachable pattern positions while name characters stream through.
// ----------------------------------------------------------------------------
// Output: the result for the name character marked last is registered in
//   the output buffer before it appears on the master side.
// Throughput: one character per cycle unless the output buffer is full;
//   each cell updates its position in parallel; star closure ripples along the row.
// Reset: asynchronous; the pattern is empty and the output buffer is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_name_matcher_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [wnm_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [15:0] char_code
	input  wire logic                             s_axis_tuser,  // [0] func
	input  wire logic                             s_axis_tlast,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [wnm_pkg::OUT_DATA_W-1:0]        m_axis_tdata   // [0] matched,
	                                                              // [1] pattern_overflow
);

	import wnm_pkg::*;

	logic [POS_W-1:0]  len_q;
	logic              complete_q;
	logic              ovf_q;
	logic              use_start_q;

	logic              acc;
	logic [POS_W-1:0]  eff_len;
	logic              fits;
	wnm_ctl_t          ctl;
	logic [CHAR_W-1:0] code;

	logic [MAX_PATTERN-1:0] link;
	logic [MAX_PATTERN-1:0] carry;
	logic [MAX_PATTERN-1:0] close;
	logic [MAX_PATTERN:0]   closed_all;
	logic [MAX_PATTERN-1:0] wr_sel;
	logic [MAX_PATTERN-1:0] valid;

	logic        push;
	logic        space;
	wnm_result_t push_data;
	wnm_result_t out_data;

	// Decode the incoming transaction
	assign acc     = s_axis_tvalid & s_axis_tready;
	assign code    = s_axis_tdata[CHAR_W-1:0];
	assign eff_len = complete_q ? '0 : len_q;
	assign fits    = eff_len < POS_W'(MAX_PATTERN);

	always_comb begin
		ctl.pat_wr    = acc & (s_axis_tuser == FUNC_PATTERN);
		ctl.new_pat   = complete_q;
		ctl.name_step = acc & (s_axis_tuser == FUNC_NAME);
		ctl.use_start = use_start_q | ~complete_q;
		ctl.code_star = code == CODE_ANY_RUN;
		ctl.code_any  = code == CODE_ANY_ONE;
	end

	// Row of pattern cells
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		assign wr_sel[i] = fits & (eff_len == POS_W'(i));
		assign valid[i]  = POS_W'(i) < len_q;

		wnm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.code      (code),
			.first     ((i == 0) ? 1'b1 : 1'b0),
			.wr_sel    (wr_sel[i]),
			.valid     (valid[i]),
			.link_in   ((i == 0) ? 1'b0 : link[(i == 0) ? 0 : i-1]),
			.carry_in  ((i == 0) ? 1'b0 : carry[(i == 0) ? 0 : i-1]),
			.close_in  ((i == 0) ? 1'b0 : close[(i == 0) ? 0 : i-1]),
			.link_out  (link[i]),
			.carry_out (carry[i]),
			.close_out (close[i]),
			.closed    (closed_all[i])
		);
	end

	// Final position past the last pattern character
	assign closed_all[MAX_PATTERN] = carry[MAX_PATTERN-1] | close[MAX_PATTERN-1];

	// Hold pattern bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			complete_q  <= 1'b1;
			ovf_q       <= 1'b0;
			use_start_q <= 1'b1;
		end else begin
			if (ctl.pat_wr) begin
				if (fits) begin
					len_q <= eff_len + POS_W'(1);
					ovf_q <= complete_q ? 1'b0 : ovf_q;
				end else begin
					len_q <= eff_len;
					ovf_q <= 1'b1;
				end
				complete_q  <= s_axis_tlast;
				use_start_q <= 1'b1;
			end else if (ctl.name_step) begin
				complete_q  <= 1'b1;
				use_start_q <= s_axis_tlast;
			end
		end
	end

	// Form the result for the last name character
	assign push                       = ctl.name_step & s_axis_tlast;
	assign push_data.pattern_overflow = ovf_q;
	assign push_data.matched          = ~ovf_q & closed_all[len_q];

	wnm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	assign s_axis_tready = space;
	assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_data.pattern_overflow,
		out_data.matched};

endmodule : wildcard_name_matcher_top

`default_nettype wire
